// ----- hw/rtl/swrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_pkg
// shared constants, types and helpers of the sliding window range check
// ----------------------------------------------------------------------------
package swrc_pkg;

    localparam int MAX_WINDOW    = 1024;
    localparam int SAMPLE_BITS   = 20;
    localparam int POSITION_BITS = 20;

    localparam int LEN_W      = 11;
    localparam int THR_W      = 20;
    localparam int OUT_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    // width that holds every effective window length, 1 .. MAX_WINDOW
    localparam int LENE_W = $clog2(MAX_WINDOW + 1);
    localparam int LCMP_W = (LEN_W > LENE_W) ? LEN_W : LENE_W;
    // position against window length compare
    localparam int PCMP_W = (POSITION_BITS > LCMP_W) ? POSITION_BITS : LCMP_W;
    // range against threshold compare
    localparam int DIFF_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    localparam int PHASE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEFT_W  = $clog2(2 * MAX_WINDOW + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'b1;

    typedef enum logic {
        MODE_RUN,
        MODE_REBUILD
    } t_mode;

    // per-cell state as seen by the neighbours
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smp;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] lo;
    } t_cell_data;

    // broadcast to every cell
    typedef struct packed {
        logic                   shift;
        logic [SAMPLE_BITS-1:0] feed;
    } t_cell_ctl;

    // zero reads as one, anything above the row length as the row length
    function automatic logic [LCMP_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LCMP_W-1:0] wide;
        wide = LCMP_W'(len);
        if (wide == '0) begin
            return LCMP_W'(1);
        end
        if (wide > LCMP_W'(MAX_WINDOW)) begin
            return LCMP_W'(MAX_WINDOW);
        end
        return wide;
    endfunction

endpackage

// ----- hw/rtl/swrc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_cell
// one cell: a raw sample tap plus the max and min of a shrinking window
// ----------------------------------------------------------------------------
module swrc_cell (
    input  logic                                 i_clk,
    input  swrc_pkg::t_cell_ctl                  i_ctl,
    input  logic                                 i_use_next,
    input  logic [swrc_pkg::SAMPLE_BITS-1:0]     i_prev_smp,
    input  swrc_pkg::t_cell_data                 i_next,
    output swrc_pkg::t_cell_data                 o_data
);

    swrc_pkg::t_cell_data r_data;
    swrc_pkg::t_cell_data n_data;

    // cell k holds the extremes of the newest (length - k) words
    always_comb begin
        n_data.smp = i_prev_smp;
        n_data.hi  = i_ctl.feed;
        n_data.lo  = i_ctl.feed;
        if (i_use_next) begin
            if (i_next.hi > i_ctl.feed) begin
                n_data.hi = i_next.hi;
            end
            if (i_next.lo < i_ctl.feed) begin
                n_data.lo = i_next.lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- hw/rtl/swrc_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_chain
// row of cells, newest word at cell 0, window extremes read at cell 0
// ----------------------------------------------------------------------------
module swrc_chain (
    input  logic                                 i_clk,
    input  swrc_pkg::t_cell_ctl                  i_ctl,
    input  logic [swrc_pkg::LCMP_W-1:0]          i_len,
    output logic [swrc_pkg::SAMPLE_BITS-1:0]     o_hi,
    output logic [swrc_pkg::SAMPLE_BITS-1:0]     o_lo,
    output logic [swrc_pkg::SAMPLE_BITS-1:0]     o_tail_smp
);

    swrc_pkg::t_cell_data w_data [swrc_pkg::MAX_WINDOW];

    for (genvar k = 0; k < swrc_pkg::MAX_WINDOW; k++) begin : g_cell
        logic                             w_use_next;
        logic [swrc_pkg::SAMPLE_BITS-1:0] w_prev;
        swrc_pkg::t_cell_data             w_next;

        // the neighbour still lies inside the window
        assign w_use_next = (i_len > swrc_pkg::LCMP_W'(k + 1));

        if (k == 0) begin : g_head
            assign w_prev = i_ctl.feed;
        end else begin : g_body
            assign w_prev = w_data[k-1].smp;
        end

        if (k == swrc_pkg::MAX_WINDOW - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_data[k+1];
        end

        swrc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_use_next (w_use_next),
            .i_prev_smp (w_prev),
            .i_next     (w_next),
            .o_data     (w_data[k])
        );
    end

    assign o_hi       = w_data[0].hi;
    assign o_lo       = w_data[0].lo;
    assign o_tail_smp = w_data[swrc_pkg::MAX_WINDOW-1].smp;

endmodule

// ----- hw/rtl/sliding_window_range_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_range_check
// sliding window max/min range check over a stream of samples
// ----------------------------------------------------------------------------
// One word is taken per clock, save during a rebuild or while a result in
// the check stage meets a full, stalled result register. Its result, if
// any, goes through the check stage and the result register; a held result
// does not stop the next word from entering. The window extremes live in a
// row of MAX_WINDOW cells that update together on every accepted word, so
// window length costs area and not time. Writing window_length starts a
// rebuild: the stored words are rotated once through the row, oldest first,
// so the cells take up the new length; no word is accepted meanwhile. threshold
// takes effect at once. Positions saturate and restart at 1 after a last word.
// ----------------------------------------------------------------------------
module sliding_window_range_check (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [swrc_pkg::SAMPLE_BITS-1:0]      i_sample,
    input  logic                                  i_last,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [swrc_pkg::OUT_W-1:0]            o_window_start,
    output logic                                  o_none_found,
    // register writes
    input  logic                                  i_cfg_we,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [swrc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam logic [swrc_pkg::POSITION_BITS-1:0] POS_MAX = '1;

    // configuration
    logic [swrc_pkg::LCMP_W-1:0]        r_len;
    logic [swrc_pkg::THR_W-1:0]         r_thr;

    // rebuild control
    swrc_pkg::t_mode                    r_mode;
    swrc_pkg::t_mode                    n_mode;
    logic [swrc_pkg::PHASE_W-1:0]       r_phase;
    logic [swrc_pkg::PHASE_W-1:0]       n_phase;
    logic [swrc_pkg::LEFT_W-1:0]        r_left;
    logic [swrc_pkg::LEFT_W-1:0]        n_left;

    // set state
    logic [swrc_pkg::POSITION_BITS-1:0] r_pos;
    logic                               r_found;

    // check stage
    logic                               r_b_valid;
    logic                               r_b_last;
    logic                               r_b_ok;
    logic [swrc_pkg::OUT_W-1:0]         r_b_start;

    // result register
    logic                               r_o_valid;
    logic [swrc_pkg::OUT_W-1:0]         r_o_start;
    logic                               r_o_none;

    logic                               w_len_wr;
    logic                               w_accept;
    logic                               w_rot;
    logic                               w_in_ready;
    logic [swrc_pkg::POSITION_BITS-1:0] w_pos_inc;
    logic                               w_ok;
    logic [swrc_pkg::POSITION_BITS-1:0] w_start;
    logic [swrc_pkg::SAMPLE_BITS-1:0]   w_hi;
    logic [swrc_pkg::SAMPLE_BITS-1:0]   w_lo;
    logic [swrc_pkg::SAMPLE_BITS-1:0]   w_tail;
    logic [swrc_pkg::SAMPLE_BITS-1:0]   w_diff;
    logic                               w_b_win;
    logic                               w_b_none;
    logic                               w_b_res;
    logic                               w_b_go;
    swrc_pkg::t_cell_ctl                w_ctl;

    assign w_len_wr = i_cfg_we && (i_cfg_index == swrc_pkg::REG_WINDOW_LENGTH);
    assign w_accept = i_in_valid && w_in_ready;

    // ---------------------------------------------------------------- cells
    // normal shift feeds the new word, rebuild feeds the oldest stored word
    assign w_ctl.shift = w_accept || w_rot;
    assign w_ctl.feed  = w_rot ? w_tail : i_sample;

    swrc_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_len      (r_len),
        .o_hi       (w_hi),
        .o_lo       (w_lo),
        .o_tail_smp (w_tail)
    );

    // ---------------------------------------------------------------- check stage
    // range of the window ending at the word now in cell 0
    assign w_diff   = w_hi - w_lo;
    assign w_b_win  = r_b_valid && r_b_ok &&
                      (swrc_pkg::DIFF_W'(w_diff) <= swrc_pkg::DIFF_W'(r_thr));
    assign w_b_none = r_b_valid && r_b_last && !r_found && !w_b_win;
    assign w_b_res  = w_b_win || w_b_none;
    // the check stage empties unless its result meets a full, stalled register
    assign w_b_go   = r_b_valid && (!w_b_res || !r_o_valid || i_out_ready);

    // ---------------------------------------------------------------- entry stage
    assign w_pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign w_ok      = (swrc_pkg::PCMP_W'(w_pos_inc) >= swrc_pkg::PCMP_W'(r_len));
    // only used when the window fits; the length is widened, not truncated
    assign w_start   = w_pos_inc - swrc_pkg::POSITION_BITS'(r_len) + 1'b1;

    // ---------------------------------------------------------------- rebuild control
    // phase counts rotations so that a rebuild always ends on a full lap
    always_comb begin
        n_phase = r_phase;
        if (w_rot) begin
            if (r_phase == swrc_pkg::PHASE_W'(swrc_pkg::MAX_WINDOW - 1)) begin
                n_phase = '0;
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
    end

    always_comb begin
        n_left = r_left;
        if (w_len_wr) begin
            if (n_phase == '0) begin
                n_left = swrc_pkg::LEFT_W'(swrc_pkg::MAX_WINDOW);
            end else begin
                n_left = swrc_pkg::LEFT_W'(2 * swrc_pkg::MAX_WINDOW)
                       - swrc_pkg::LEFT_W'(n_phase);
            end
        end else if (w_rot) begin
            n_left = r_left - 1'b1;
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            swrc_pkg::MODE_RUN: begin
                if (w_len_wr) begin
                    n_mode = swrc_pkg::MODE_REBUILD;
                end
            end
            swrc_pkg::MODE_REBUILD: begin
                if (!w_len_wr && w_rot && (r_left == swrc_pkg::LEFT_W'(1))) begin
                    n_mode = swrc_pkg::MODE_RUN;
                end
            end
            default: n_mode = swrc_pkg::MODE_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        w_rot      = 1'b0;
        w_in_ready = 1'b0;
        unique case (r_mode)
            swrc_pkg::MODE_RUN: begin
                w_in_ready = !r_b_valid || w_b_go;
            end
            swrc_pkg::MODE_REBUILD: begin
                w_rot = !r_b_valid;
            end
            default: begin
                w_rot      = 1'b0;
                w_in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= swrc_pkg::LCMP_W'(1);
            r_thr     <= '0;
            r_mode    <= swrc_pkg::MODE_RUN;
            r_phase   <= '0;
            r_left    <= '0;
            r_pos     <= '0;
            r_found   <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_left  <= n_left;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    swrc_pkg::REG_WINDOW_LENGTH:
                        r_len <= swrc_pkg::eff_len(i_cfg_data[swrc_pkg::LEN_W-1:0]);
                    swrc_pkg::REG_THRESHOLD:
                        r_thr <= i_cfg_data[swrc_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_pos <= i_last ? '0 : w_pos_inc;
            end

            // found flag belongs to the set, settled as items leave the check
            if (w_b_go) begin
                r_found <= r_b_last ? 1'b0 : (r_found || w_b_win);
            end

            if (w_accept) begin
                r_b_valid <= 1'b1;
            end else if (w_b_go) begin
                r_b_valid <= 1'b0;
            end

            if (w_b_go && w_b_res) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_last  <= i_last;
            r_b_ok    <= w_ok;
            r_b_start <= swrc_pkg::OUT_W'(w_start);
        end
        if (w_b_go && w_b_res) begin
            r_o_start <= w_b_win ? r_b_start : '0;
            r_o_none  <= !w_b_win;
        end
    end

    assign o_in_ready     = w_in_ready;
    assign o_out_valid    = r_o_valid;
    assign o_window_start = r_o_start;
    assign o_none_found   = r_o_none;

`ifndef SYNTHESIS
    a_none_has_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_found |-> o_window_start == '0)
        else $error("none_found word carries a nonzero start");

    a_rebuild_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == swrc_pkg::MODE_REBUILD |-> r_left != '0)
        else $error("rebuild running with no rotations left");

    a_run_on_full_lap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == swrc_pkg::MODE_RUN |-> r_phase == '0)
        else $error("stored words left rotated after rebuild");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_b_valid))
        else $error("result offered without an item in the check stage");
`endif

endmodule

// ----- sim/swrc_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_result_checker
// watches the sample, result and register ports of the range check, works
// out the result each accepted word should cause and compares it, field by
// field, with the oldest result still due
// ----------------------------------------------------------------------------
module swrc_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [swrc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                             i_last,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [swrc_pkg::OUT_W-1:0]       i_window_start,
    input  logic                             i_none_found,
    input  logic                             i_cfg_we,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    import swrc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] start;
        logic             none;
    } t_window_result;

    // ring of recent samples, contents only trusted once written in the set
    logic [SAMPLE_BITS-1:0]   history [MAX_WINDOW];
    int unsigned              history_ptr;
    logic [POSITION_BITS-1:0] set_position;
    logic                     set_matched;
    logic [LEN_W-1:0]         length_reg;
    logic [THR_W-1:0]         threshold_reg;
    t_window_result           starts_due [$];
    t_window_result           oldest;
    int                       mismatch_count = 0;

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // take one word, push the result it causes, if any
    task automatic scan_window(input logic [SAMPLE_BITS-1:0] smp, input logic is_last);
        int unsigned            span;
        int unsigned            idx;
        logic [SAMPLE_BITS-1:0] top_v;
        logic [SAMPLE_BITS-1:0] bot_v;
        t_window_result         res;
        if (length_reg == '0) begin
            span = 1;
        end else if (length_reg > MAX_WINDOW) begin
            span = MAX_WINDOW;
        end else begin
            span = length_reg;
        end
        history[history_ptr] = smp;
        history_ptr = (history_ptr + 1) % MAX_WINDOW;
        if (set_position != '1) begin
            set_position++;
        end
        if (set_position >= span) begin
            top_v = '0;
            bot_v = '1;
            idx   = history_ptr;
            for (int k = 0; k < span; k++) begin
                idx = (idx == 0) ? MAX_WINDOW - 1 : idx - 1;
                if (history[idx] > top_v) top_v = history[idx];
                if (history[idx] < bot_v) bot_v = history[idx];
            end
            if (top_v - bot_v <= threshold_reg) begin
                res.start   = OUT_W'(set_position - span + 1);
                res.none    = 1'b0;
                set_matched = 1'b1;
                starts_due.push_back(res);
            end
        end
        if (is_last) begin
            if (!set_matched) begin
                res.start = '0;
                res.none  = 1'b1;
                starts_due.push_back(res);
            end
            set_position = '0;
            set_matched  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            history_ptr   = 0;
            set_position  = '0;
            set_matched   = 1'b0;
            length_reg    = LEN_W'(1);
            threshold_reg = '0;
            starts_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (starts_due.size() == 0) begin
                    flag_mismatch($sformatf("result start %0d none %0b with nothing due",
                                            i_window_start, i_none_found));
                end else begin
                    oldest = starts_due.pop_front();
                    if (i_window_start !== oldest.start) begin
                        flag_mismatch($sformatf("window_start got %0d want %0d",
                                                i_window_start, oldest.start));
                    end
                    if (i_none_found !== oldest.none) begin
                        flag_mismatch($sformatf("none_found got %0b want %0b",
                                                i_none_found, oldest.none));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW_LENGTH: length_reg = i_cfg_data[LEN_W-1:0];
                    REG_THRESHOLD:     threshold_reg = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                scan_window(i_sample, i_last);
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= starts_due.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the sliding window range check: a directed opening over the
// register extremes, threshold boundary, short sets and a length change in
// mid-set, a back-pressure burst, a full-size window set, then random data
// sets under changing registers with random gaps on both channels
// ----------------------------------------------------------------------------
module tb;
    import swrc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 1_000_000;
    // results pass the check stage and the result register, keep a wide margin
    localparam int SETTLE      = 8;
    localparam int RANDOM_WORDS = 20;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   i_last;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [OUT_W-1:0]       o_window_start;
    logic                   o_none_found;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int words_sent = 0;
    // both sides run without gaps while set
    bit steady = 1'b0;
    // one-off long stall for the result side, picked up by its own process
    int rx_hold = 0;

    sliding_window_range_check u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_window_start (o_window_start),
        .o_none_found   (o_none_found),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    swrc_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_window_start (o_window_start),
        .i_none_found   (o_none_found),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // hang guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // offer one word, return at the edge that accepts it; valid stays high so
    // a back-to-back word keeps it up without a drop
    task automatic send_word(input logic [SAMPLE_BITS-1:0] smp, input logic is_last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        i_last     <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // a run of samples in base .. base+spread, clipped to the sample range;
    // the final one carries last when the set is to be closed
    task automatic send_set(input int count, input int base, input int spread,
                            input bit close);
        int v;
        for (int k = 0; k < count; k++) begin
            v = base + $urandom_range(0, spread);
            if (v > 20'hFFFFF) v = 20'hFFFFF;
            send_word(SAMPLE_BITS'(v), close && (k == count - 1));
        end
    endtask

    // window length then threshold on consecutive edges
    task automatic write_regs(input logic [CFG_DATA_W-1:0] len_data,
                              input logic [CFG_DATA_W-1:0] thr_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WINDOW_LENGTH;
        i_cfg_data  <= len_data;
        @(posedge i_clk);
        i_cfg_index <= REG_THRESHOLD;
        i_cfg_data  <= thr_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stop offering, let every due result drain, then allow for words that
    // cause no result but may still be in flight
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // result side: random stall per word, or the requested long hold
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int base;
        int spread;
        int w;
        int eff;
        int thr;
        int count;
        int first_random;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_last      <= 1'b0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_WINDOW_LENGTH;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: window of one, zero threshold, so every word hits
        send_word(20'h00000, 1'b0);
        send_word(20'hFFFFF, 1'b1);

        // zero length acts as one, upper data bits outside the register ignored
        wait_idle();
        write_regs(20'hFF800, 20'h00000);
        send_word(20'd5, 1'b0);
        send_word(20'd5, 1'b0);
        send_word(20'd7, 1'b1);

        // short set gives none found; full threshold passes extreme samples
        wait_idle();
        write_regs(20'd3, 20'hFFFFF);
        send_word(20'd1, 1'b0);
        send_word(20'd2, 1'b1);
        send_word(20'h00000, 1'b0);
        send_word(20'hFFFFF, 1'b0);
        send_word(20'h00000, 1'b0);
        send_word(20'hFFFFF, 1'b1);

        // zero threshold, nothing qualifies in the whole set
        wait_idle();
        write_regs(20'd3, 20'h00000);
        send_word(20'd1, 1'b0);
        send_word(20'd2, 1'b0);
        send_word(20'd3, 1'b1);

        // length shrinks in mid-set, the new window applies from the next word
        send_word(20'd9, 1'b0);
        send_word(20'd9, 1'b0);
        wait_idle();
        write_regs(20'd2, 20'h00000);
        send_word(20'd9, 1'b1);

        // threshold boundary: difference equal passes, one above fails
        wait_idle();
        write_regs(20'd2, 20'd1);
        send_word(20'd4, 1'b0);
        send_word(20'd5, 1'b0);
        send_word(20'd7, 1'b1);

        // back-pressure: every word hits while the result side holds off,
        // so the block has to stall its input
        wait_idle();
        write_regs(20'd1, 20'hFFFFF);
        steady  = 1'b1;
        rx_hold = 300;
        for (int k = 0; k < 16; k++) begin
            send_word(SAMPLE_BITS'($urandom), (k == 15) || ($urandom_range(0, 9) == 0));
        end
        // sender pauses until everything has come back
        wait_idle();
        steady = 1'b0;

        // oversized length acts as the full row: one long set, then a short one
        write_regs(20'h007FF, 20'd15);
        base = $urandom_range(0, 20'hFFFFF - 15);
        send_set(MAX_WINDOW + 2, base, 15, 1'b1);
        send_set(2, base, 15, 1'b1);

        // random phases, mostly small windows, registers changed between phases
        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            wait_idle();
            w   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            eff = (w == 0) ? 1 : w;
            case ($urandom_range(0, 4))
                0:       thr = 0;
                1:       thr = $urandom_range(0, 8);
                2:       thr = $urandom_range(0, 256);
                3:       thr = 20'hFFFFF;
                default: thr = $urandom_range(0, 20'hFFFFF);
            endcase
            write_regs(CFG_DATA_W'(($urandom_range(0, 511) << LEN_W) | w), CFG_DATA_W'(thr));
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) begin
                // some sets too short for a window, most long enough for several
                if ($urandom_range(0, 4) == 0) begin
                    count = $urandom_range(1, eff);
                end else begin
                    count = $urandom_range(eff, 3 * eff + 4);
                end
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = thr;
                    2:       spread = thr + $urandom_range(1, 4);
                    default: spread = 20'hFFFFF;
                endcase
                base = $urandom_range(0, 20'hFFFFF);
                send_set(count, base, spread, 1'b1);
            end
            // leave a set open so the next setting lands in mid-set
            if ($urandom_range(0, 3) == 0) begin
                send_set($urandom_range(1, eff), base, spread, 1'b0);
            end
        end
        steady = 1'b0;

        // close any open set, then drain
        send_word(SAMPLE_BITS'($urandom), 1'b1);
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/swrc_pkg.sv
hw/rtl/swrc_cell.sv
hw/rtl/swrc_chain.sv
hw/rtl/sliding_window_range_check.sv
sim/swrc_result_checker.sv
sim/tb.sv
